>>> rtl/linear_fraction_fp32_macros.svh
// Assertion macros for the linear fraction block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef LINEAR_FRACTION_FP32_MACROS_SVH
`define LINEAR_FRACTION_FP32_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/lfp_pkg.sv
// Shared types, constants and float32 helper functions for the linear fraction block.
// No dependencies.
package lfp_pkg;

  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] PosInf     = 32'h7F80_0000;

  localparam int unsigned DivSteps = 27;  // quotient bits produced by the divider

  localparam logic [2:0] RegScaleNum = 3'd0;
  localparam logic [2:0] RegShiftNum = 3'd1;
  localparam logic [2:0] RegScaleDen = 3'd2;
  localparam logic [2:0] RegShiftDen = 3'd3;

  localparam logic [31:0] ScaleNumRst = 32'h3F80_0000;
  localparam logic [31:0] ShiftNumRst = 32'h0000_0000;
  localparam logic [31:0] ScaleDenRst = 32'h0000_0000;
  localparam logic [31:0] ShiftDenRst = 32'h3F80_0000;

  // Unrounded value handed to the rounding unit: sgn * mant * 2^expo, or a ready result.
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sgn;
    logic [63:0]        mant;
    logic signed [12:0] expo;
  } lfp_rnd_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'h0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'h0);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 31'h0;
  endfunction

  function automatic logic [23:0] dec_mant(input logic [31:0] x);
    return {|x[30:23], x[22:0]};
  endfunction

  function automatic logic signed [12:0] dec_exp(input logic [31:0] x);
    logic signed [12:0] e;
    if (x[30:23] == 8'h00) begin
      e = -13'sd149;
    end else begin
      e = $signed({5'b0, x[30:23]}) - 13'sd150;
    end
    return e;
  endfunction

  function automatic logic [5:0] msb64(input logic [63:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // Right shift that folds every dropped bit into the lsb.
  function automatic logic [62:0] shr_sticky(input logic [62:0] m, input logic [12:0] k);
    logic [62:0] mask;
    logic [62:0] res;
    mask = '0;
    if (k >= 13'd63) begin
      res = {62'b0, |m};
    end else begin
      mask = ~({63{1'b1}} << k[5:0]);
      res  = (m >> k[5:0]) | {62'b0, |(m & mask)};
    end
    return res;
  endfunction

endpackage

>>> rtl/lfp_fma.sv
// Five-stage exact fused multiply-add front end: x*y+z, unrounded.
// Depends on lfp_pkg; its output feeds lfp_round.
module lfp_fma (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [31:0]      x_i,
  input  logic [31:0]      y_i,
  input  logic [31:0]      z_i,
  output logic             vld_o,
  output lfp_pkg::lfp_rnd_t res_o
);

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sp;
    logic               sz;
    logic               zz;
    logic [47:0]        mp;
    logic signed [12:0] ep;
    logic [23:0]        mz;
    logic signed [12:0] ez;
  } f1_t;

  typedef struct packed {
    f1_t        b;
    logic [5:0] np;
    logic [5:0] nz;
  } f2_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sp;
    logic               sz;
    logic               zz;
    logic [62:0]        pa;
    logic [62:0]        za;
    logic signed [12:0] epn;
    logic signed [12:0] ezn;
  } f3_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sp;
    logic               sz;
    logic [62:0]        pa;
    logic [62:0]        za;
    logic signed [12:0] ec;
  } f4_t;

  logic [4:0]         vld_q;
  f1_t                f1_d, f1_q;
  f2_t                f2_d, f2_q;
  f3_t                f3_d, f3_q;
  f4_t                f4_d, f4_q;
  lfp_pkg::lfp_rnd_t  f5_d, f5_q;
  logic               sp;
  logic [63:0]        sum;

  assign sp = x_i[31] ^ y_i[31];

  // Stage 1: special operands, mantissa product.
  always_comb begin
    f1_d.spec      = 1'b1;
    f1_d.spec_bits = '0;
    if (lfp_pkg::is_nan(x_i)) begin
      f1_d.spec_bits = x_i | lfp_pkg::QuietBit;
    end else if (lfp_pkg::is_nan(y_i)) begin
      f1_d.spec_bits = y_i | lfp_pkg::QuietBit;
    end else if (lfp_pkg::is_nan(z_i)) begin
      f1_d.spec_bits = z_i | lfp_pkg::QuietBit;
    end else if ((lfp_pkg::is_inf(x_i) && lfp_pkg::is_zero(y_i)) ||
                 (lfp_pkg::is_zero(x_i) && lfp_pkg::is_inf(y_i))) begin
      f1_d.spec_bits = lfp_pkg::DefaultNan;
    end else if (lfp_pkg::is_inf(x_i) || lfp_pkg::is_inf(y_i)) begin
      if (lfp_pkg::is_inf(z_i) && (z_i[31] != sp)) begin
        f1_d.spec_bits = lfp_pkg::DefaultNan;
      end else begin
        f1_d.spec_bits = {sp, lfp_pkg::PosInf[30:0]};
      end
    end else if (lfp_pkg::is_inf(z_i)) begin
      f1_d.spec_bits = z_i;
    end else if (lfp_pkg::is_zero(x_i) || lfp_pkg::is_zero(y_i)) begin
      if (lfp_pkg::is_zero(z_i)) begin
        f1_d.spec_bits = {sp & z_i[31], 31'h0};
      end else begin
        f1_d.spec_bits = z_i;
      end
    end else begin
      f1_d.spec = 1'b0;
    end
    f1_d.sp = sp;
    f1_d.sz = z_i[31];
    f1_d.zz = lfp_pkg::is_zero(z_i);
    f1_d.mp = {24'b0, lfp_pkg::dec_mant(x_i)} * {24'b0, lfp_pkg::dec_mant(y_i)};
    f1_d.ep = lfp_pkg::dec_exp(x_i) + lfp_pkg::dec_exp(y_i);
    f1_d.mz = lfp_pkg::dec_mant(z_i);
    f1_d.ez = lfp_pkg::dec_exp(z_i);
  end

  // Stage 2: leading-one positions.
  always_comb begin
    f2_d.b  = f1_q;
    f2_d.np = 6'd62 - lfp_pkg::msb64({16'b0, f1_q.mp});
    f2_d.nz = 6'd62 - lfp_pkg::msb64({40'b0, f1_q.mz});
  end

  // Stage 3: left-justify both terms.
  always_comb begin
    f3_d.spec      = f2_q.b.spec;
    f3_d.spec_bits = f2_q.b.spec_bits;
    f3_d.sp        = f2_q.b.sp;
    f3_d.sz        = f2_q.b.sz;
    f3_d.zz        = f2_q.b.zz;
    f3_d.pa        = 63'(f2_q.b.mp) << f2_q.np;
    f3_d.za        = 63'(f2_q.b.mz) << f2_q.nz;
    f3_d.epn       = f2_q.b.ep - $signed({7'b0, f2_q.np});
    f3_d.ezn       = f2_q.b.ez - $signed({7'b0, f2_q.nz});
  end

  // Stage 4: align the smaller term.
  always_comb begin
    f4_d.spec      = f3_q.spec;
    f4_d.spec_bits = f3_q.spec_bits;
    f4_d.sp        = f3_q.sp;
    f4_d.sz        = f3_q.sz;
    f4_d.pa        = f3_q.pa;
    f4_d.za        = f3_q.za;
    f4_d.ec        = f3_q.epn;
    if (f3_q.zz) begin
      f4_d.za = '0;
    end else if (f3_q.epn >= f3_q.ezn) begin
      f4_d.za = lfp_pkg::shr_sticky(f3_q.za, 13'(f3_q.epn - f3_q.ezn));
    end else begin
      f4_d.pa = lfp_pkg::shr_sticky(f3_q.pa, 13'(f3_q.ezn - f3_q.epn));
      f4_d.ec = f3_q.ezn;
    end
  end

  // Stage 5: add or subtract magnitudes; exact cancellation gives +0.
  always_comb begin
    if (f4_q.sp == f4_q.sz) begin
      sum       = {1'b0, f4_q.pa} + {1'b0, f4_q.za};
      f5_d.sgn  = f4_q.sp;
    end else if (f4_q.pa >= f4_q.za) begin
      sum       = {1'b0, f4_q.pa} - {1'b0, f4_q.za};
      f5_d.sgn  = f4_q.sp;
    end else begin
      sum       = {1'b0, f4_q.za} - {1'b0, f4_q.pa};
      f5_d.sgn  = f4_q.sz;
    end
    f5_d.spec      = f4_q.spec || (sum == 64'h0);
    f5_d.spec_bits = f4_q.spec ? f4_q.spec_bits : 32'h0;
    f5_d.mant      = sum;
    f5_d.expo      = f4_q.ec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
      f3_q <= f3_d;
      f4_q <= f4_d;
      f5_q <= f5_d;
    end
  end

  assign vld_o = vld_q[4];
  assign res_o = f5_q;

endmodule

>>> rtl/lfp_round.sv
// Three-stage round-to-nearest-even packer to float32 with subnormal support.
// Depends on lfp_pkg.
module lfp_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  lfp_pkg::lfp_rnd_t rnd_i,
  output logic              vld_o,
  output logic [31:0]       res_o
);

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sgn;
    logic [63:0]        mant;
    logic signed [12:0] sh;
    logic signed [12:0] fexp;
  } r1_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_bits;
    logic        sgn;
    logic [23:0] kept;
    logic        rup;
    logic [7:0]  fexp;
    logic        ovf;
  } r2_t;

  logic [2:0]         vld_q;
  r1_t                r1_d, r1_q;
  r2_t                r2_d, r2_q;
  logic [31:0]        r3_d, r3_q;
  logic signed [12:0] sh_a, sh_t, neg;
  logic [6:0]         amt;
  logic [127:0]       wide;
  logic [63:0]        left;
  logic [31:0]        bits;

  // Stage 1: shift amount from leading one and subnormal floor.
  always_comb begin
    sh_a           = $signed({7'b0, lfp_pkg::msb64(rnd_i.mant)}) - 13'sd23;
    sh_t           = -13'sd149 - rnd_i.expo;
    r1_d.spec      = rnd_i.spec;
    r1_d.spec_bits = rnd_i.spec_bits;
    r1_d.sgn       = rnd_i.sgn;
    r1_d.mant      = rnd_i.mant;
    r1_d.sh        = (sh_t > sh_a) ? sh_t : sh_a;
    r1_d.fexp      = rnd_i.expo + r1_d.sh + 13'sd149;
  end

  // Stage 2: shift, guard and sticky.
  always_comb begin
    neg  = -r1_q.sh;
    amt  = ($signed(r1_q.sh) > 13'sd127) ? 7'd127 : r1_q.sh[6:0];
    wide = {r1_q.mant, 64'h0} >> amt;
    left = r1_q.mant << neg[4:0];
    r2_d.spec      = r1_q.spec;
    r2_d.spec_bits = r1_q.spec_bits;
    r2_d.sgn       = r1_q.sgn;
    r2_d.fexp      = r1_q.fexp[7:0];
    r2_d.ovf       = $signed(r1_q.fexp) > 13'sd254;
    if ($signed(r1_q.sh) > 13'sd0) begin
      r2_d.kept = wide[87:64];
      r2_d.rup  = wide[63] & ((|wide[62:0]) | wide[64]);
    end else begin
      r2_d.kept = left[23:0];
      r2_d.rup  = 1'b0;
    end
  end

  // Stage 3: increment and pack; a carry past the top exponent saturates to infinity.
  always_comb begin
    bits = {1'b0, r2_q.fexp, 23'h0} + {8'h0, r2_q.kept} + {31'h0, r2_q.rup};
    if (bits >= lfp_pkg::PosInf) begin
      bits = lfp_pkg::PosInf;
    end
    if (r2_q.spec) begin
      r3_d = r2_q.spec_bits;
    end else if (r2_q.ovf) begin
      r3_d = {r2_q.sgn, lfp_pkg::PosInf[30:0]};
    end else begin
      r3_d = {r2_q.sgn, bits[30:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
    end
  end

  assign vld_o = vld_q[2];
  assign res_o = r3_q;

endmodule

>>> rtl/lfp_div.sv
// Pipelined restoring float32 divider, one quotient bit per stage, unrounded output.
// Depends on lfp_pkg; its output feeds lfp_round.
module lfp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [31:0]       n_i,
  input  logic [31:0]       d_i,
  output logic              vld_o,
  output lfp_pkg::lfp_rnd_t res_o
);

  localparam int unsigned Last = lfp_pkg::DivSteps - 1;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sgn;
    logic [23:0]        mn;
    logic [23:0]        md;
    logic signed [12:0] en;
    logic signed [12:0] ed;
  } d1_t;

  typedef struct packed {
    logic                           spec;
    logic [31:0]                    spec_bits;
    logic                           sgn;
    logic signed [12:0]             expo;
    logic [23:0]                    md;
    logic [23:0]                    rem;
    logic [lfp_pkg::DivSteps-1:0]   quo;
  } dst_t;

  logic [1:0]          pre_vld_q;
  logic [Last:0]       st_vld_q;
  logic                out_vld_q;
  d1_t                 d1_d, d1_q, d2_d, d2_q;
  dst_t                st_d [lfp_pkg::DivSteps];
  dst_t                st_q [lfp_pkg::DivSteps];
  lfp_pkg::lfp_rnd_t   out_d, out_q;
  logic                sgn;
  logic [4:0]          kn, kd;
  logic                q_top;

  assign sgn = n_i[31] ^ d_i[31];

  // Stage 1: special operands and unpack.
  always_comb begin
    d1_d.spec      = 1'b1;
    d1_d.spec_bits = '0;
    if (lfp_pkg::is_nan(n_i)) begin
      d1_d.spec_bits = n_i | lfp_pkg::QuietBit;
    end else if (lfp_pkg::is_nan(d_i)) begin
      d1_d.spec_bits = d_i | lfp_pkg::QuietBit;
    end else if ((lfp_pkg::is_inf(n_i) && lfp_pkg::is_inf(d_i)) ||
                 (lfp_pkg::is_zero(n_i) && lfp_pkg::is_zero(d_i))) begin
      d1_d.spec_bits = lfp_pkg::DefaultNan;
    end else if (lfp_pkg::is_inf(n_i) || lfp_pkg::is_zero(d_i)) begin
      d1_d.spec_bits = {sgn, lfp_pkg::PosInf[30:0]};
    end else if (lfp_pkg::is_inf(d_i) || lfp_pkg::is_zero(n_i)) begin
      d1_d.spec_bits = {sgn, 31'h0};
    end else begin
      d1_d.spec = 1'b0;
    end
    d1_d.sgn = sgn;
    d1_d.mn  = lfp_pkg::dec_mant(n_i);
    d1_d.md  = lfp_pkg::dec_mant(d_i);
    d1_d.en  = lfp_pkg::dec_exp(n_i);
    d1_d.ed  = lfp_pkg::dec_exp(d_i);
  end

  // Stage 2: normalize subnormal mantissas to bit 23.
  always_comb begin
    kn   = 5'(6'd23 - lfp_pkg::msb64({40'b0, d1_q.mn}));
    kd   = 5'(6'd23 - lfp_pkg::msb64({40'b0, d1_q.md}));
    d2_d = d1_q;
    d2_d.mn = d1_q.mn << kn;
    d2_d.md = d1_q.md << kd;
    d2_d.en = d1_q.en - $signed({8'b0, kn});
    d2_d.ed = d1_q.ed - $signed({8'b0, kd});
  end

  // Stage 3: top quotient bit; the mantissa ratio lies in (1/2, 2).
  always_comb begin
    q_top              = d2_q.mn >= d2_q.md;
    st_d[0].spec       = d2_q.spec;
    st_d[0].spec_bits  = d2_q.spec_bits;
    st_d[0].sgn        = d2_q.sgn;
    st_d[0].expo       = d2_q.en - d2_q.ed - 13'(lfp_pkg::DivSteps - 1);
    st_d[0].md         = d2_q.md;
    st_d[0].rem        = q_top ? (d2_q.mn - d2_q.md) : d2_q.mn;
    st_d[0].quo        = '0;
    st_d[0].quo[Last]  = q_top;
  end

  // Remaining quotient bits, one compare-subtract per stage.
  for (genvar j = 1; j < lfp_pkg::DivSteps; j++) begin : g_step
    logic [24:0] r2;
    logic        ge;
    always_comb begin
      r2 = {st_q[j-1].rem, 1'b0};
      ge = r2 >= {1'b0, st_q[j-1].md};
      st_d[j]     = st_q[j-1];
      st_d[j].rem = ge ? 24'(r2 - {1'b0, st_q[j-1].md}) : r2[23:0];
      st_d[j].quo[Last-j] = ge;
    end
  end

  // Fold a nonzero remainder into the quotient lsb.
  always_comb begin
    out_d.spec      = st_q[Last].spec;
    out_d.spec_bits = st_q[Last].spec_bits;
    out_d.sgn       = st_q[Last].sgn;
    out_d.expo      = st_q[Last].expo;
    out_d.mant      = {37'h0, st_q[Last].quo[Last:1],
                       st_q[Last].quo[0] | (st_q[Last].rem != 24'h0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
      st_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      pre_vld_q <= {pre_vld_q[0], vld_i};
      st_vld_q  <= {st_vld_q[Last-1:0], pre_vld_q[1]};
      out_vld_q <= st_vld_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q  <= d1_d;
      d2_q  <= d2_d;
      st_q  <= st_d;
      out_q <= out_d;
    end
  end

  assign vld_o = out_vld_q;
  assign res_o = out_q;

endmodule

>>> rtl/linear_fraction_fp32.sv
// Linear fraction unit: quotient = (scale_num*a + shift_num) / (scale_den*b + shift_den).
// Depends on lfp_pkg, lfp_fma, lfp_round, lfp_div and linear_fraction_fp32_macros.svh.
//
// The block accepts one float32 pair (num_value, den_value) per clock and returns one
// float32 quotient per pair, in order. Numerator and denominator are each a fused
// multiply-add rounded once; the quotient is a correctly rounded division. All rounding
// is to nearest even, subnormals are kept, and NaN/infinity handling follows SSE rules
// (first NaN quieted, invalid operations give 0xFFC00000). Unless stalled, throughput is
// one item per cycle; 42 register stages lead from the input transfer to the result: one
// input register, five multiply-add stages, three rounding stages, thirty divider stages
// (a 27-stage compare-subtract chain producing one quotient bit each) and three final
// rounding stages. The whole pipeline advances as one: it holds while a finished result
// waits on out_stall_i, and the input then stalls too; bubbles are not squeezed out.
// The four scale/shift registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i
// (indexes 0 to 3; higher indexes are dropped) and must only change while idle.
`include "linear_fraction_fp32_macros.svh"

module linear_fraction_fp32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] num_value_i,
  input  logic [31:0] den_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] quotient_o
);

  logic [31:0]       scale_num_q, shift_num_q, scale_den_q, shift_den_q;
  logic              in_vld_q;
  logic [31:0]       num_value_q, den_value_q;
  logic              adv;
  logic              num_fma_vld, den_fma_vld;
  lfp_pkg::lfp_rnd_t num_fma, den_fma;
  logic              num_vld, den_vld;
  logic [31:0]       num_res, den_res;
  logic              div_vld;
  lfp_pkg::lfp_rnd_t div_res;

  // Advance every stage together unless a finished result is being held.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Configuration registers; write at any index, drop unused ones.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_num_q <= lfp_pkg::ScaleNumRst;
      shift_num_q <= lfp_pkg::ShiftNumRst;
      scale_den_q <= lfp_pkg::ScaleDenRst;
      shift_den_q <= lfp_pkg::ShiftDenRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lfp_pkg::RegScaleNum: scale_num_q <= cfg_wdata_i;
        lfp_pkg::RegShiftNum: shift_num_q <= cfg_wdata_i;
        lfp_pkg::RegScaleDen: scale_den_q <= cfg_wdata_i;
        lfp_pkg::RegShiftDen: shift_den_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register: capture a transfer whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_value_q <= num_value_i;
      den_value_q <= den_value_i;
    end
  end

  // Numerator and denominator run side by side with equal latency.
  lfp_fma u_num_fma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (in_vld_q),
    .x_i    (scale_num_q),
    .y_i    (num_value_q),
    .z_i    (shift_num_q),
    .vld_o  (num_fma_vld),
    .res_o  (num_fma)
  );

  lfp_fma u_den_fma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (in_vld_q),
    .x_i    (scale_den_q),
    .y_i    (den_value_q),
    .z_i    (shift_den_q),
    .vld_o  (den_fma_vld),
    .res_o  (den_fma)
  );

  lfp_round u_num_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (num_fma_vld),
    .rnd_i  (num_fma),
    .vld_o  (num_vld),
    .res_o  (num_res)
  );

  lfp_round u_den_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (den_fma_vld),
    .rnd_i  (den_fma),
    .vld_o  (den_vld),
    .res_o  (den_res)
  );

  // Both operands arrive in the same cycle, so either valid qualifies the divide.
  lfp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (num_vld),
    .n_i    (num_res),
    .d_i    (den_res),
    .vld_o  (div_vld),
    .res_o  (div_res)
  );

  // The last rounding stage is the output register.
  lfp_round u_quo_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (div_vld),
    .rnd_i  (div_res),
    .vld_o  (out_valid_o),
    .res_o  (quotient_o)
  );

  // Numerator and denominator paths stay in lockstep.
  `LFP_ASSERT_IMPL(a_lockstep, num_vld || den_vld, num_vld && den_vld)
  // Every NaN leaving the block is quiet.
  `LFP_ASSERT_IMPL(a_nan_quiet, out_valid_o && lfp_pkg::is_nan(quotient_o), quotient_o[22])
  // A held pipeline keeps its intermediate operands.
  `LFP_ASSERT_NEXT(a_freeze, in_stall_o && num_vld, num_vld && $stable(num_res))

endmodule

>>> tb/lfp_checker.sv
// Checker for linear_fraction_fp32: follows the config port, predicts each quotient
// from the accepted operand transfers and compares results in order. Depends on lfp_pkg.
module lfp_checker
  import lfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [31:0] num_value_i,
  input  logic [31:0] den_value_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [31:0] quotient_o,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] coef_scale_num, coef_shift_num, coef_scale_den, coef_shift_den;
  logic [31:0] quotients_due[$];
  int          mismatches;

  assign fail_count_o = mismatches + quotients_due.size();

  function automatic bit fp_nan(logic [31:0] x);
    return x[30:0] > PosInf[30:0];
  endfunction

  function automatic bit fp_inf(logic [31:0] x);
    return x[30:0] == PosInf[30:0];
  endfunction

  function automatic bit fp_zero(logic [31:0] x);
    return x[30:0] == 31'h0;
  endfunction

  function automatic int top_bit(logic [63:0] m);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    return p;
  endfunction

  function automatic logic [63:0] sticky_shr(logic [63:0] m, int k);
    logic [63:0] mask;
    if (k <= 0) return m;
    if (k >= 63) return {63'b0, |m};
    mask = (64'd1 << k) - 64'd1;
    return (m >> k) | {63'b0, |(m & mask)};
  endfunction

  function automatic void unpack_fp(input logic [31:0] x, output logic [63:0] m,
                                    output int e);
    if (x[30:23] == 8'h0) begin
      m = {41'b0, x[22:0]};
      e = -149;
    end else begin
      m = {40'b0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  // Round sign * m * 2^e to nearest even; the lsb of m may carry sticky.
  function automatic logic [31:0] round_fp(logic s, logic [63:0] m, int e);
    int          p, sh, t, field;
    logic [63:0] kept, rem, half;
    logic [31:0] bits;
    p  = top_bit(m);
    sh = p - 23;
    t  = -149 - e;
    if (t > sh) sh = t;
    if (sh > 62) begin
      m  = sticky_shr(m, sh - 62);
      e  = e + sh - 62;
      sh = 62;
    end
    field = e + sh + 150;
    if (field - 1 > 254) return {s, PosInf[30:0]};
    if (sh <= 0) begin
      kept = m << (-sh);
    end else begin
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      kept = m >> sh;
      if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    end
    bits = 32'((field - 1) << 23) + kept[31:0];
    if (bits >= PosInf) bits = PosInf;
    return {s, bits[30:0]};
  endfunction

  function automatic logic [31:0] mul_add_fp(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic        sp, sz, sr;
    logic [63:0] mx, my, mz, mp, pa, za, sum;
    int          ex, ey, ez, ep, np, nz, epn, ezn, ec;
    sp = x[31] ^ y[31];
    sz = z[31];
    if (fp_nan(x)) return x | QuietBit;
    if (fp_nan(y)) return y | QuietBit;
    if (fp_nan(z)) return z | QuietBit;
    if ((fp_inf(x) && fp_zero(y)) || (fp_zero(x) && fp_inf(y))) return DefaultNan;
    if (fp_inf(x) || fp_inf(y)) begin
      if (fp_inf(z) && sz != sp) return DefaultNan;
      return {sp, PosInf[30:0]};
    end
    if (fp_inf(z)) return z;
    unpack_fp(x, mx, ex);
    unpack_fp(y, my, ey);
    unpack_fp(z, mz, ez);
    mp = mx * my;
    ep = ex + ey;
    if (mp == 0) begin
      if (mz == 0) return {sp & sz, 31'b0};
      return z;
    end
    if (mz == 0) return round_fp(sp, mp, ep);
    np  = 62 - top_bit(mp);
    nz  = 62 - top_bit(mz);
    pa  = mp << np;
    epn = ep - np;
    za  = mz << nz;
    ezn = ez - nz;
    if (epn >= ezn) begin
      za = sticky_shr(za, epn - ezn);
      ec = epn;
    end else begin
      pa = sticky_shr(pa, ezn - epn);
      ec = ezn;
    end
    if (sp == sz) begin
      sum = pa + za;
      sr  = sp;
    end else if (pa >= za) begin
      sum = pa - za;
      sr  = sp;
    end else begin
      sum = za - pa;
      sr  = sz;
    end
    // exact cancellation is always +0
    if (sum == 0) return 32'h0;
    return round_fp(sr, sum, ec);
  endfunction

  function automatic logic [31:0] divide_fp(logic [31:0] n, logic [31:0] d);
    logic        s;
    logic [63:0] mn, md, q, r;
    int          en, ed, k;
    s = n[31] ^ d[31];
    if (fp_nan(n)) return n | QuietBit;
    if (fp_nan(d)) return d | QuietBit;
    if ((fp_inf(n) && fp_inf(d)) || (fp_zero(n) && fp_zero(d))) return DefaultNan;
    if (fp_inf(n)) return {s, PosInf[30:0]};
    if (fp_inf(d)) return {s, 31'b0};
    if (fp_zero(d)) return {s, PosInf[30:0]};
    if (fp_zero(n)) return {s, 31'b0};
    unpack_fp(n, mn, en);
    unpack_fp(d, md, ed);
    k  = 23 - top_bit(mn);
    mn = mn << k;
    en = en - k;
    k  = 23 - top_bit(md);
    md = md << k;
    ed = ed - k;
    q = (mn << 40) / md;
    r = (mn << 40) % md;
    if (r != 0) q[0] = 1'b1;
    return round_fp(s, q, en - ed - 40);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_scale_num <= ScaleNumRst;
      coef_shift_num <= ShiftNumRst;
      coef_scale_den <= ScaleDenRst;
      coef_shift_den <= ShiftDenRst;
      mismatches     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegScaleNum: coef_scale_num <= cfg_wdata_i;
          RegShiftNum: coef_shift_num <= cfg_wdata_i;
          RegScaleDen: coef_scale_den <= cfg_wdata_i;
          RegShiftDen: coef_shift_den <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        quotients_due.push_back(divide_fp(
          mul_add_fp(coef_scale_num, num_value_i, coef_shift_num),
          mul_add_fp(coef_scale_den, den_value_i, coef_shift_den)));
      end
      if (out_valid_o && !out_stall_i) begin
        if (quotients_due.size() == 0) begin
          $error("quotient: unexpected result %h", quotient_o);
          mismatches <= mismatches + 1;
        end else if (quotients_due[0] !== quotient_o) begin
          $error("quotient: expected %h actual %h", quotients_due[0], quotient_o);
          mismatches <= mismatches + 1;
          void'(quotients_due.pop_front());
        end else begin
          void'(quotients_due.pop_front());
        end
      end
    end
  end
endmodule

>>> tb/tb.sv
// Top of the linear_fraction_fp32 testbench: clock, reset, config writes, operand
// stimulus with idle/stall phases and the verdict. Depends on lfp_pkg and lfp_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfp_pkg::*;

  localparam logic [2:0] RegUnused = 3'd5;  // no register here; the write must be dropped
  localparam int CycleLimit = 300000;
  localparam int PhaseItems = 75;
  localparam int DrainCycles = 60;  // a bit past the 42-stage pipeline

  // traffic shapes
  localparam int ModeSteady   = 0;
  localparam int ModeSendIdle = 1;
  localparam int ModeRecvIdle = 2;
  localparam int ModeBothIdle = 3;
  localparam int ModeHold     = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] num_value_i = '0;
  logic [31:0] den_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] quotient_o;
  int          fail_count;
  int          traffic_mode = ModeSteady;
  int          hold_cycles = 0;
  int          pairs_sent = 0;
  int          quotients_seen = 0;
  int          cycle_count = 0;

  linear_fraction_fp32 uut (.*);

  lfp_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .num_value_i, .den_value_i,
    .out_valid_o, .out_stall_i, .quotient_o,
    .fail_count_o(fail_count)
  );

  always #10 clk_i = ~clk_i;

  // Receiver side: random stalls per mode, or one long hold-off so the pipe backs up.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (out_valid_o && !out_stall_i) quotients_seen <= quotients_seen + 1;
    if (traffic_mode == ModeHold) begin
      out_stall_i <= (hold_cycles < 300);
      if (hold_cycles < 300) hold_cycles <= hold_cycles + 1;
    end else begin
      hold_cycles <= 0;
      case (traffic_mode)
        ModeRecvIdle: out_stall_i <= ($urandom_range(0, 99) < 52);
        ModeBothIdle: out_stall_i <= ($urandom_range(0, 99) < 13);
        default:      out_stall_i <= 1'b0;
      endcase
    end
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Pick a float32 pattern biased toward the corners: zeros, infinities, NaNs,
  // subnormals, the top of the range and values near one.
  function automatic logic [31:0] pick_float();
    logic        s;
    logic [22:0] f;
    s = 1'($urandom_range(0, 1));
    f = 23'($urandom);
    case ($urandom_range(0, 11))
      0, 1:    return $urandom;
      2:       return {s, 31'h0};
      3:       return {s, 8'hFF, 23'h0};
      4:       return {s, 8'hFF, f | 23'h1};
      5:       return {s, 8'h00, f};
      6:       return {s, 8'hFE, f};
      7:       return {s, 8'($urandom_range(1, 20)), f};
      8, 9:    return {s, 8'($urandom_range(124, 130)), f};
      default: return {s, 8'($urandom_range(90, 165)), f};
    endcase
  endfunction

  // Mostly ordinary coefficients, now and then a corner value.
  function automatic logic [31:0] pick_coef();
    if ($urandom_range(0, 3) == 0) return pick_float();
    return {1'($urandom_range(0, 1)), 8'($urandom_range(118, 134)), 23'($urandom)};
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_coefs(input logic [31:0] sn, input logic [31:0] hn,
                           input logic [31:0] sd, input logic [31:0] hd);
    write_reg(RegScaleNum, sn);
    write_reg(RegShiftNum, hn);
    write_reg(RegScaleDen, sd);
    write_reg(RegShiftDen, hd);
  endtask

  // Hold valid until the transfer happens; drop it only for an idle gap.
  task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
    int pct;
    pct = (traffic_mode == ModeSendIdle) ? 52 : (traffic_mode == ModeBothIdle) ? 13 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < pct) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    num_value_i <= a;
    den_value_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    pairs_sent++;
  endtask

  // Drain the pipe before any register changes.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (quotients_seen != pairs_sent) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients give a / 1 (finite b): a passes, -0 as +0, NaNs come back quiet.
    send_pair(32'h0000_0000, 32'h3F80_0000);
    send_pair(32'h8000_0000, 32'h0000_0000);
    send_pair(32'h7F80_0000, 32'hFFFF_FFFF);
    send_pair(32'hFF80_0000, 32'h7F80_0000);
    send_pair(32'h7F80_0001, 32'h1234_5678);
    send_pair(32'h0000_0001, 32'h8000_0001);
    send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_pair(32'h3F80_0000, 32'h7FC0_0000);
    wait_drained();

    // Numerator a - 1, denominator b: zero over zero, division by zero, inf over inf,
    // exact cancellation, overflow and underflow of the quotient.
    set_coefs(32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h0000_0000);
    write_reg(RegUnused, 32'hDEAD_BEEF);
    send_pair(32'h3F80_0000, 32'h0000_0000);
    send_pair(32'h4040_0000, 32'h8000_0000);
    send_pair(32'h7F80_0000, 32'hFF80_0000);
    send_pair(32'h4000_0000, 32'h7F80_0000);
    send_pair(32'h7F7F_FFFF, 32'h0000_0001);
    send_pair(32'h3F80_0001, 32'h7F7F_FFFF);
    send_pair(32'h4040_0000, 32'h4040_0000);
    wait_drained();

    // Zero times infinity and infinity minus infinity inside the multiply-adds.
    set_coefs(32'h0000_0000, 32'hFF80_0000, 32'h7F80_0000, 32'h7F80_0000);
    send_pair(32'h7F80_0000, 32'h3F80_0000);
    send_pair(32'h3F80_0000, 32'hBF80_0000);
    send_pair(32'hFFFF_FFFF, 32'h7FA0_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    wait_drained();

    // Random phases, each with its own coefficients and one of the traffic shapes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_coefs(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001);
        5: set_coefs(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        default: set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
      endcase
      case (ph)
        1: traffic_mode = ModeSendIdle;
        2: traffic_mode = ModeRecvIdle;
        3: traffic_mode = ModeBothIdle;
        4: traffic_mode = ModeHold;
        default: traffic_mode = ModeSteady;
      endcase
      for (int i = 0; i < PhaseItems; i++) send_pair(pick_float(), pick_float());
      wait_drained();
      traffic_mode = ModeSteady;
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> linear_fraction_fp32.f
+incdir+rtl
rtl/lfp_pkg.sv
rtl/lfp_fma.sv
rtl/lfp_round.sv
rtl/lfp_div.sv
rtl/linear_fraction_fp32.sv
tb/lfp_checker.sv
tb/tb.sv
